FILE: rtl/bprt_pkg.sv
package bprt_pkg;

    // event selector carried on s_tuser
    localparam logic [1:0] FUNC_BPDU     = 2'd0;
    localparam logic [1:0] FUNC_TICK     = 2'd1;
    localparam logic [1:0] FUNC_TC_START = 2'd2;

    // bpdu type codes
    localparam logic [7:0] TYPE_CONF    = 8'h00;
    localparam logic [7:0] TYPE_RCONF   = 8'h02;
    localparam logic [7:0] TYPE_TCNOTIF = 8'h80;

    // length limits in bytes
    localparam logic [10:0] MAX_FRAME  = 11'd1500;
    localparam logic [10:0] LEN_COMMON = 11'd4;
    localparam logic [10:0] LEN_CONF   = 11'd35;
    localparam logic [10:0] LEN_RCONF  = 11'd36;

    // hello clamp in seconds and train length
    localparam logic [7:0] HELLO_MIN = 8'd1;
    localparam logic [7:0] HELLO_MAX = 8'd10;
    localparam logic [2:0] TC_LIMIT  = 3'd5;

    // classified work for the back end
    typedef logic [2:0] kind_t;
    localparam kind_t KIND_NOP      = 3'd0;
    localparam kind_t KIND_WARN     = 3'd1;
    localparam kind_t KIND_ROOT     = 3'd2;
    localparam kind_t KIND_TICK     = 3'd3;
    localparam kind_t KIND_TC_START = 3'd4;

    typedef struct packed {
        kind_t       kind;
        logic        flag_tc;
        logic [63:0] rid;
        logic [4:0]  hold;
    } tc_item_t;

    // result bits as placed on m_tdata
    typedef struct packed {
        logic tc_active;
        logic send_tc;
        logic inhibit;
        logic root_accepted;
        logic status;
    } tc_result_t;

    // queue status seen by the two ends
    typedef struct packed {
        logic full;
        logic valid;
    } q_stat_t;

endpackage

FILE: rtl/bprt_front.sv
module bprt_front (
    input  logic [1:0]         func,
    input  logic [10:0]        frame_length,
    input  logic [15:0]        protocol_id,
    input  logic [7:0]         bpdu_type,
    input  logic [7:0]         bpdu_flags,
    input  logic [63:0]        root_identifier,
    input  logic [15:0]        message_age,
    input  logic [15:0]        max_age,
    input  logic [15:0]        hello_time,
    output bprt_pkg::tc_item_t item
);
    import bprt_pkg::*;

    logic [10:0] len_sat;
    logic [7:0]  secs_raw;
    logic [4:0]  secs;
    kind_t       bpdu_kind;

    // saturate the frame length
    assign len_sat = (frame_length > MAX_FRAME) ? MAX_FRAME : frame_length;

    // hold time in ticks: three times the clamped hello seconds
    assign secs_raw = hello_time[15:8];
    always_comb begin
        if (secs_raw < HELLO_MIN) begin
            secs = 5'(HELLO_MIN);
        end else if (secs_raw > HELLO_MAX) begin
            secs = 5'(HELLO_MAX);
        end else begin
            secs = secs_raw[4:0];
        end
    end

    // bpdu sanity checks
    always_comb begin
        bpdu_kind = KIND_NOP;
        if (len_sat < LEN_COMMON) begin
            bpdu_kind = KIND_WARN;
        end else if (protocol_id != 16'd0) begin
            bpdu_kind = KIND_NOP;
        end else begin
            unique case (bpdu_type)
                TYPE_CONF: begin
                    if (len_sat < LEN_CONF || message_age >= max_age) begin
                        bpdu_kind = KIND_WARN;
                    end else begin
                        bpdu_kind = KIND_ROOT;
                    end
                end
                TYPE_RCONF: begin
                    bpdu_kind = (len_sat < LEN_RCONF) ? KIND_WARN : KIND_ROOT;
                end
                TYPE_TCNOTIF: bpdu_kind = KIND_NOP;
                default:      bpdu_kind = KIND_WARN;
            endcase
        end
    end

    // event classification
    always_comb begin
        item.flag_tc = bpdu_flags[0];
        item.rid     = root_identifier;
        item.hold    = 5'((secs << 1) + secs);
        unique case (func)
            FUNC_BPDU:     item.kind = bpdu_kind;
            FUNC_TICK:     item.kind = KIND_TICK;
            FUNC_TC_START: item.kind = KIND_TC_START;
            default:       item.kind = KIND_NOP;
        endcase
    end

endmodule

FILE: rtl/bprt_queue.sv
module bprt_queue #(
    parameter int DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  bprt_pkg::tc_item_t  push_item,
    input  logic                pop,
    output bprt_pkg::tc_item_t  head_item,
    output bprt_pkg::q_stat_t   stat
);
    import bprt_pkg::*;

    // DEPTH must be a power of two, at least two; the queue itself does not enforce it
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tc_item_t           mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop) begin
            rd_ptr_next = PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop) begin
            count_next = CNT_W'(count_reg + 1'b1);
        end else if (pop && !push) begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item  = mem[rd_ptr_reg];
    assign stat.valid = (count_reg != '0);
    assign stat.full  = (count_reg == CNT_W'(DEPTH));

endmodule

FILE: rtl/bprt_back.sv
module bprt_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  bprt_pkg::q_stat_t  q_stat,
    input  bprt_pkg::tc_item_t item,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata   // status, root_accepted, inhibit, send_tc, tc_active
);
    import bprt_pkg::*;

    logic [63:0] root_id_reg,      root_id_next;
    logic        root_held_reg,    root_held_next;
    logic [4:0]  hold_ticks_reg,   hold_ticks_next;
    logic        hold_expired_reg, hold_expired_next;
    logic [2:0]  tc_cnt_reg,       tc_cnt_next;
    logic        tc_armed_reg,     tc_armed_next;
    logic        out_valid_reg,    out_valid_next;
    tc_result_t  out_reg,          out_next;
    tc_result_t  res;
    logic [2:0]  cnt_inc;

    // take the head item whenever the output stage is free or draining
    assign pop = q_stat.valid && (!out_valid_reg || m_tready);

    // execute one item against the tracker state
    always_comb begin
        root_id_next      = root_id_reg;
        root_held_next    = root_held_reg;
        hold_ticks_next   = hold_ticks_reg;
        hold_expired_next = hold_expired_reg;
        tc_cnt_next       = tc_cnt_reg;
        tc_armed_next     = tc_armed_reg;
        res               = '0;
        cnt_inc           = 3'(tc_cnt_reg + 1'b1);
        unique case (item.kind)
            KIND_NOP: begin
            end
            KIND_WARN: begin
                res.status = 1'b1;
            end
            KIND_ROOT: begin
                if (!root_held_reg || hold_expired_reg || item.rid <= root_id_reg) begin
                    hold_ticks_next   = item.hold;
                    hold_expired_next = 1'b0;
                    root_held_next    = 1'b1;
                    root_id_next      = item.rid;
                    res.root_accepted = 1'b1;
                    res.inhibit       = (item.rid != root_id_reg);
                    if (item.flag_tc && tc_cnt_reg != 3'd0) begin
                        tc_armed_next = 1'b0;
                        tc_cnt_next   = 3'd0;
                    end
                end
            end
            KIND_TICK: begin
                if (hold_ticks_reg != 5'd0) begin
                    hold_ticks_next = 5'(hold_ticks_reg - 1'b1);
                end else if (root_held_reg) begin
                    hold_expired_next = 1'b1;
                end
                if (tc_armed_reg) begin
                    res.send_tc = 1'b1;
                    if (cnt_inc > TC_LIMIT) begin
                        tc_armed_next = 1'b0;
                        tc_cnt_next   = 3'd0;
                    end else begin
                        tc_cnt_next = cnt_inc;
                    end
                end
            end
            KIND_TC_START: begin
                tc_cnt_next   = 3'd1;
                tc_armed_next = 1'b1;
            end
            default: begin
            end
        endcase
        res.tc_active = tc_armed_next;
    end

    // output register
    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (pop) begin
            out_valid_next = 1'b1;
            out_next       = res;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_id_reg      <= '0;
            root_held_reg    <= 1'b0;
            hold_ticks_reg   <= '0;
            hold_expired_reg <= 1'b0;
            tc_cnt_reg       <= '0;
            tc_armed_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (pop) begin
                root_id_reg      <= root_id_next;
                root_held_reg    <= root_held_next;
                hold_ticks_reg   <= hold_ticks_next;
                hold_expired_reg <= hold_expired_next;
                tc_cnt_reg       <= tc_cnt_next;
                tc_armed_reg     <= tc_armed_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg};

`ifndef SYNTHESIS
    // a running train always has a nonzero count, a stopped one a zero count
    a_train_count: assert property (@(posedge aclk) disable iff (!aresetn)
        tc_armed_reg == (tc_cnt_reg != 3'd0))
        else $error("train flag and count disagree");

    a_train_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        tc_cnt_reg <= TC_LIMIT)
        else $error("train count beyond limit");

    a_hold_range: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_ticks_reg <= 5'd30)
        else $error("hold time beyond three times the hello clamp");

    // inhibit only accompanies an accepted root
    a_inhibit_root: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> m_tdata[1])
        else $error("inhibit without accepted root");

    // a stalled result is not overwritten
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
`endif

endmodule

FILE: rtl/bpdu_root_tracker_tc_notify_unit.sv
// path: an accepted transfer is written to the queue, then executed by the back end into the register driving m_tvalid
// throughput: one item per cycle while the output register is empty or m_tready is high; state updates on the pop
// s_tready drops only when the decoupling queue (QUEUE_DEPTH entries) is full
// reset: synchronous active-low aresetn clears the root, hold, train state and queue
module bpdu_root_tracker_tc_notify_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // frame_length, protocol_id, bpdu_type, bpdu_flags, root_identifier,
    // message_age, max_age, hello_time, zero fill
    input  logic [159:0] s_tdata,
    input  logic [1:0]   s_tuser,   // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata    // status, root_accepted, inhibit, send_tc, tc_active
);
    import bprt_pkg::*;

    tc_item_t front_item;
    tc_item_t head_item;
    q_stat_t  q_stat;
    logic     push;
    logic     pop;

    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && s_tready;

    // classify the incoming event
    bprt_front u_front (
        .func            (s_tuser),
        .frame_length    (s_tdata[10:0]),
        .protocol_id     (s_tdata[26:11]),
        .bpdu_type       (s_tdata[34:27]),
        .bpdu_flags      (s_tdata[42:35]),
        .root_identifier (s_tdata[106:43]),
        .message_age     (s_tdata[122:107]),
        .max_age         (s_tdata[138:123]),
        .hello_time      (s_tdata[154:139]),
        .item            (front_item)
    );

    // decoupling queue
    bprt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .head_item (head_item),
        .stat      (q_stat)
    );

    // tracker state and result register
    bprt_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .item     (head_item),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
